@@ design/tfr_pkg.sv @@
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types and constants of the tracking frame receiver: result codes,
// framing bytes, register indexes and the parser-to-tracker record.
// ----------------------------------------------------------------------------
`default_nettype none

package tfr_pkg;

    // Result codes reported with every item.
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_OK    = 3'd1,
        EV_CRC   = 3'd2,
        EV_LEN   = 3'd3,
        EV_TYPE  = 3'd4,
        EV_DUP   = 3'd5,
        EV_GAP   = 3'd6,
        EV_STALE = 3'd7
    } event_t;

    // Input item kinds.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_INTERBYTE = 2'd1;
    localparam logic [1:0] CFG_STALE     = 2'd2;

    localparam logic [15:0] INTERBYTE_RESET = 16'd50;
    localparam logic [15:0] STALE_RESET     = 16'd200;

    // Framing.
    localparam logic [7:0]  HDR1_BYTE   = 8'hAA;
    localparam logic [7:0]  HDR2_BYTE   = 8'h5A;
    localparam logic [7:0]  TRACK_TYPE  = 8'h21;
    localparam logic [7:0]  TRACK_LEN   = 8'd13;
    localparam logic [7:0]  MAX_PAYLOAD = 8'd32;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    // Parser outcome for one byte, handed to the tracking state.
    typedef struct packed {
        logic        clr_valid;
        event_t      event_code;
        logic        frame_good;
        logic [7:0]  seq;
        logic [7:0]  flags;
        logic [7:0]  mask;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] error_x;
        logic [15:0] error_y;
        logic [15:0] frame_rate;
    } parse_res_t;

endpackage

`default_nettype wire

@@ design/tfr_parser.sv @@
// ----------------------------------------------------------------------------
// tfr_parser
// Byte-level frame parser: header search, type and length checks, payload
// capture, CRC-16 update and end-of-frame decode of tracking fields.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_fire,
    input  wire logic               resync,
    input  wire logic [7:0]         byte_value,
    output tfr_pkg::parse_res_t     result
);
    import tfr_pkg::*;

    localparam int STORE_DEPTH = 13;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_TYPE = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_CRCL = 3'd5,
        PH_CRCH = 3'd6
    } phase_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [5:0]  length_reg, length_next;
    logic [5:0]  index_reg, index_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [7:0]  store_reg [STORE_DEPTH];

    phase_t      cur_phase;
    logic [5:0]  index_plus;
    logic        store_we;
    logic [15:0] crc_rx;

    assign cur_phase  = resync ? PH_HDR1 : phase_reg;
    assign index_plus = index_reg + 6'd1;
    assign crc_rx     = {byte_value, crc_lo_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        length_next = length_reg;
        index_next  = index_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        store_we    = 1'b0;

        result            = '0;
        result.event_code = EV_NONE;
        result.seq        = store_reg[0];
        result.flags      = store_reg[1];
        result.center_x   = {store_reg[3], store_reg[2]};
        result.center_y   = {store_reg[5], store_reg[4]};
        result.error_x    = {store_reg[7], store_reg[6]};
        result.error_y    = {store_reg[9], store_reg[8]};
        result.mask       = store_reg[10];
        result.frame_rate = {store_reg[12], store_reg[11]};

        if (byte_fire)
        begin
            if (resync)
            begin
                phase_next  = PH_HDR1;
                length_next = '0;
                index_next  = '0;
            end
            case (cur_phase)
                PH_HDR1:
                begin
                    if (byte_value == HDR1_BYTE)
                        phase_next = PH_HDR2;
                end
                PH_HDR2:
                begin
                    if (byte_value == HDR2_BYTE)
                        phase_next = PH_TYPE;
                    else if (byte_value != HDR1_BYTE)
                        phase_next = PH_HDR1;
                end
                PH_TYPE:
                begin
                    type_next  = byte_value;
                    crc_next   = crc_step(CRC_INIT, byte_value);
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    index_next = '0;
                    crc_next   = crc_step(crc_reg, byte_value);
                    if (byte_value > MAX_PAYLOAD ||
                        (type_reg == TRACK_TYPE && byte_value != TRACK_LEN))
                    begin
                        result.clr_valid  = 1'b1;
                        result.event_code = EV_LEN;
                        phase_next        = PH_HDR1;
                        length_next       = '0;
                    end
                    else
                    begin
                        length_next = byte_value[5:0];
                        phase_next  = (byte_value == 8'd0) ? PH_CRCL : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    // Only the first TRACK_LEN payload bytes are stored, whatever the frame type.
                    store_we   = ({2'b00, index_reg} < TRACK_LEN);
                    index_next = index_plus;
                    crc_next   = crc_step(crc_reg, byte_value);
                    if (index_plus >= length_reg)
                        phase_next = PH_CRCL;
                end
                PH_CRCL:
                begin
                    crc_lo_next = byte_value;
                    phase_next  = PH_CRCH;
                end
                PH_CRCH:
                begin
                    result.clr_valid = 1'b1;
                    if (crc_rx != crc_reg)
                        result.event_code = EV_CRC;
                    else if (type_reg != TRACK_TYPE)
                        result.event_code = EV_TYPE;
                    else if (length_reg != TRACK_LEN[5:0])
                        result.event_code = EV_LEN;
                    else
                    begin
                        // The tracking state decides between accept and duplicate.
                        result.clr_valid  = 1'b0;
                        result.frame_good = 1'b1;
                    end
                    phase_next  = PH_HDR1;
                    length_next = '0;
                    index_next  = '0;
                end
                default:
                begin
                    result.clr_valid = 1'b1;
                    phase_next       = PH_HDR1;
                    length_next      = '0;
                    index_next       = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR1;
            type_reg   <= '0;
            length_reg <= '0;
            index_reg  <= '0;
            crc_reg    <= CRC_INIT;
            crc_lo_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            index_reg  <= index_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[index_reg[STORE_AW-1:0]] <= byte_value;
    end

endmodule

`default_nettype wire

@@ design/tfr_tracker.sv @@
// ----------------------------------------------------------------------------
// tfr_tracker
// Tracking state: gap and age timers, sequence check, decoded record and
// the control-valid flag with its flag and tag geometry checks.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_tracker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire logic                action,
    input  wire tfr_pkg::parse_res_t result,
    input  wire logic                mode,
    input  wire logic                mode_clr,
    input  wire logic [15:0]         interbyte_timeout,
    input  wire logic [15:0]         stale_timeout,
    output logic                     gap_hit,
    output tfr_pkg::event_t          event_code,
    output logic                     valid_flag,
    output logic [15:0]              center_x,
    output logic [15:0]              center_y,
    output logic signed [15:0]       error_x,
    output logic signed [15:0]       error_y,
    output logic [7:0]               status_flags,
    output logic [7:0]               tags_seen,
    output logic [15:0]              frame_rate_x10,
    output logic [7:0]               frame_sequence
);
    import tfr_pkg::*;

    function automatic logic flags_ok(input logic [7:0] flags, input logic [7:0] mask);
        logic four;
        logic diag;
        logic geo;
        four = flags[1];
        diag = flags[6];
        if ((mask & 8'hF0) != 8'h00 || four == diag)
            geo = 1'b0;
        else if (four)
            geo = (mask == 8'h0F);
        else
            geo = ((mask & 8'h06) == 8'h06) || ((mask & 8'h09) == 8'h09);
        return flags[0] && flags[2] && ((flags & 8'hB8) == 8'h00) && geo;
    endfunction

    logic [15:0] gap_reg, gap_next;
    logic [15:0] age_reg, age_next;
    logic        byte_seen_reg, byte_seen_next;
    logic        seq_seen_reg, seq_seen_next;
    logic        valid_reg, valid_next;
    logic        take;

    logic [15:0]        cx_reg, cy_reg, fps_reg;
    logic signed [15:0] ex_reg, ey_reg;
    logic [7:0]         flags_reg, mask_reg, seq_reg;

    assign gap_hit = byte_seen_reg && (gap_reg > interbyte_timeout);

    always_comb
    begin
        gap_next       = gap_reg;
        age_next       = age_reg;
        byte_seen_next = byte_seen_reg;
        seq_seen_next  = seq_seen_reg;
        valid_next     = valid_reg;
        event_code     = EV_NONE;
        take           = 1'b0;

        if (fire)
        begin
            if (action == ACT_TICK)
            begin
                if (gap_reg != 16'hFFFF)
                    gap_next = gap_reg + 16'd1;
                if (age_reg != 16'hFFFF)
                    age_next = age_reg + 16'd1;
                if (valid_reg && age_next > stale_timeout)
                begin
                    valid_next = 1'b0;
                    event_code = EV_STALE;
                end
            end
            else
            begin
                if (gap_hit)
                begin
                    valid_next = 1'b0;
                    event_code = EV_GAP;
                end
                gap_next       = '0;
                byte_seen_next = 1'b1;
                if (result.clr_valid)
                    valid_next = 1'b0;
                if (result.event_code != EV_NONE)
                    event_code = result.event_code;
                if (result.frame_good)
                begin
                    if (seq_seen_reg && result.seq == seq_reg)
                    begin
                        valid_next = 1'b0;
                        event_code = EV_DUP;
                    end
                    else
                    begin
                        take          = 1'b1;
                        seq_seen_next = 1'b1;
                        age_next      = '0;
                        valid_next    = mode && flags_ok(result.flags, result.mask);
                        event_code    = EV_OK;
                    end
                end
            end
        end

        // A change of mode always drops control, whatever else happens.
        if (mode_clr)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg       <= '0;
            age_reg       <= '0;
            byte_seen_reg <= 1'b0;
            seq_seen_reg  <= 1'b0;
            valid_reg     <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            ex_reg        <= '0;
            ey_reg        <= '0;
            flags_reg     <= '0;
            mask_reg      <= '0;
            fps_reg       <= '0;
            seq_reg       <= '0;
        end
        else
        begin
            gap_reg       <= gap_next;
            age_reg       <= age_next;
            byte_seen_reg <= byte_seen_next;
            seq_seen_reg  <= seq_seen_next;
            valid_reg     <= valid_next;
            if (take)
            begin
                cx_reg    <= result.center_x;
                cy_reg    <= result.center_y;
                ex_reg    <= result.error_x;
                ey_reg    <= result.error_y;
                flags_reg <= result.flags;
                mask_reg  <= result.mask;
                fps_reg   <= result.frame_rate;
                seq_reg   <= result.seq;
            end
        end
    end

    assign valid_flag     = valid_reg;
    assign center_x       = cx_reg;
    assign center_y       = cy_reg;
    assign error_x        = ex_reg;
    assign error_y        = ey_reg;
    assign status_flags   = flags_reg;
    assign tags_seen      = mask_reg;
    assign frame_rate_x10 = fps_reg;
    assign frame_sequence = seq_reg;

endmodule

`default_nettype wire

@@ design/tracking_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// tracking_frame_receiver
// Serial tracking-frame receiver: parses CRC-protected frames from a byte
// stream, keeps the latest tracking record and judges it fit for control.
// ----------------------------------------------------------------------------
// An accepted item enters the input register and then passes one
// parse-and-track step into the result register, which offers it.
// Throughput: one item per cycle unless out_stall holds the result; the
// byte-wide CRC update and the frame checks all sit in that single step.
// Reset (asynchronous, active low) returns the parser to header search,
// clears record, timers and control valid, and loads the register defaults.
`default_nettype none

module tracking_frame_receiver (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               action,
    input  wire logic [7:0]         byte_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              event_res,
    output logic                    control_valid,
    output logic [15:0]             center_x,
    output logic [15:0]             center_y,
    output logic signed [15:0]      error_x,
    output logic signed [15:0]      error_y,
    output logic [7:0]              status_flags,
    output logic [7:0]              tags_seen,
    output logic [15:0]             frame_rate_x10,
    output logic [7:0]              frame_sequence,
    input  wire logic               cfg_write_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import tfr_pkg::*;

    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [7:0]  s1_byte_reg;
    logic        out_valid_reg;
    event_t      event_reg;

    logic        mode_reg;
    logic [15:0] interbyte_reg;
    logic [15:0] stale_reg;

    logic        advance;
    logic        fire;
    logic        byte_fire;
    logic        mode_clr;
    logic        gap_hit;
    event_t      step_event;
    parse_res_t  parse_res;

    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && advance;
    assign byte_fire = fire && (s1_action_reg == ACT_BYTE);
    assign in_stall  = s1_valid_reg && !advance;
    assign mode_clr  = cfg_write_en && (cfg_index == CFG_MODE) && (cfg_data[0] != mode_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            event_reg     <= EV_NONE;
        end
        else
        begin
            if (in_valid && !in_stall)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
            begin
                out_valid_reg <= fire;
                event_reg     <= step_event;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_action_reg <= action;
            s1_byte_reg   <= byte_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            interbyte_reg <= INTERBYTE_RESET;
            stale_reg     <= STALE_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_MODE:      mode_reg      <= cfg_data[0];
                CFG_INTERBYTE: interbyte_reg <= cfg_data;
                CFG_STALE:     stale_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    tfr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_fire  (byte_fire),
        .resync     (gap_hit),
        .byte_value (s1_byte_reg),
        .result     (parse_res)
    );

    tfr_tracker u_tracker (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire),
        .action            (s1_action_reg),
        .result            (parse_res),
        .mode              (mode_reg),
        .mode_clr          (mode_clr),
        .interbyte_timeout (interbyte_reg),
        .stale_timeout     (stale_reg),
        .gap_hit           (gap_hit),
        .event_code        (step_event),
        .valid_flag        (control_valid),
        .center_x          (center_x),
        .center_y          (center_y),
        .error_x           (error_x),
        .error_y           (error_y),
        .status_flags      (status_flags),
        .tags_seen         (tags_seen),
        .frame_rate_x10    (frame_rate_x10),
        .frame_sequence    (frame_sequence)
    );

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;

    // Every rejection or timeout leaves control invalid.
    a_reject_clears_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_CRC || event_res == EV_LEN ||
                      event_res == EV_TYPE || event_res == EV_DUP ||
                      event_res == EV_GAP || event_res == EV_STALE)
        |-> !control_valid)
        else $error("rejection event with control still valid");

    // Control can only be valid while tracking mode is on.
    a_valid_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
        control_valid |-> mode_reg)
        else $error("control valid outside tracking mode");

    // A tick never produces a frame event.
    a_tick_events: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_action_reg == ACT_TICK)
        |=> (event_res == EV_NONE || event_res == EV_STALE))
        else $error("tick produced a frame event");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: regression bench for the tracking frame receiver
// Feeds serial bytes and millisecond ticks, predicts every result with an
// in-bench frame tracker, and compares each result field by field. An opening
// table covers header search, length and CRC errors and unknown types. Random
// phases follow, mostly well-formed tracking frames mixed with noise, cut
// frames and tick bursts, under several timeout settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tfr_pkg::*;

    localparam int CLK_HALF = 5;
    localparam int RUN_LIMIT_NS = 2_000_000;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 8;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Parser position inside a frame.
    typedef enum logic [2:0] {
        HUNT_AA, HUNT_5A, TAKE_TYPE, TAKE_LEN, TAKE_BODY, TAKE_CRC_LO, TAKE_CRC_HI
    } hunt_t;

    typedef struct packed {
        event_t             ev;
        logic               ctl;
        logic [15:0]        cx;
        logic [15:0]        cy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic [7:0]         flags;
        logic [7:0]         tags;
        logic [15:0]        fps;
        logic [7:0]         seq;
    } track_result_t;

    typedef struct packed {
        logic       act;
        logic [7:0] b;
    } serial_item_t;

    typedef enum logic [2:0] {
        ROW_TICK, ROW_BYTE, ROW_CRC_LO, ROW_CRC_HI, ROW_CRC_BAD
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] b;
        logic       pinned;
        event_t     ev;
    } opening_row_t;

    // Rows with pinned set carry the event that the row must produce.
    localparam opening_row_t OPENING [26] = '{
        '{ROW_TICK,    8'h00, 1'b1, EV_NONE},
        '{ROW_BYTE,    8'h00, 1'b1, EV_NONE},
        '{ROW_BYTE,    8'hFF, 1'b1, EV_NONE},
        '{ROW_BYTE,    8'hAA, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'hAA, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'h5A, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'h21, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'h0E, 1'b1, EV_LEN},
        '{ROW_BYTE,    8'hAA, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'h5A, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'hFF, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'h21, 1'b1, EV_LEN},
        '{ROW_BYTE,    8'hAA, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'h5A, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'h00, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'h00, 1'b0, EV_NONE},
        '{ROW_CRC_LO,  8'h00, 1'b0, EV_NONE},
        '{ROW_CRC_HI,  8'h00, 1'b1, EV_TYPE},
        '{ROW_BYTE,    8'hAA, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'h5A, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'h7F, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'h01, 1'b0, EV_NONE},
        '{ROW_BYTE,    8'h80, 1'b0, EV_NONE},
        '{ROW_CRC_LO,  8'h00, 1'b0, EV_NONE},
        '{ROW_CRC_BAD, 8'h00, 1'b1, EV_CRC},
        '{ROW_TICK,    8'h00, 1'b1, EV_NONE}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic [7:0]         byte_value;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         event_res;
    logic               control_valid;
    logic [15:0]        center_x;
    logic [15:0]        center_y;
    logic signed [15:0] error_x;
    logic signed [15:0] error_y;
    logic [7:0]         status_flags;
    logic [7:0]         tags_seen;
    logic [15:0]        frame_rate_x10;
    logic [7:0]         frame_sequence;
    logic               cfg_write_en;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    tracking_frame_receiver dut (.*);

    always #CLK_HALF clk = ~clk;

    // Frame tracker state.
    hunt_t         hunt;
    logic [7:0]    cur_type;
    logic [5:0]    cur_len;
    logic [5:0]    body_idx;
    logic [7:0]    body_buf [32];
    logic [15:0]   crc_acc;
    logic [15:0]   crc_got;
    logic          seq_known;
    logic [7:0]    prev_seq;
    track_result_t latest;
    logic          ctl_ok;
    logic          any_byte;
    logic [15:0]   gap_ms_cnt;
    logic [15:0]   age_ms_cnt;
    logic          mode_on;
    logic [15:0]   gap_limit;
    logic [15:0]   stale_limit;

    track_result_t expected_q [$];
    serial_item_t  stim_q [$];
    int            fail_count = 0;
    int            items_in = 0;
    int            results_out = 0;
    int            ctl_results = 0;
    int            ev_hits [8];
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    int            hold_orders = 0;
    logic [7:0]    seq_plan;

    function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        return v;
    endfunction

    function automatic logic flags_usable(logic [7:0] f, logic [7:0] m);
        // Bit 1 marks a four-tag lock, bit 6 a diagonal pair; exactly one is set.
        if (!f[0] || !f[2] || (f & 8'hB8) != 8'h00)
            return 1'b0;
        if ((m & 8'hF0) != 8'h00 || f[1] == f[6])
            return 1'b0;
        if (f[1])
            return m == 8'h0F;
        return ((m & 8'h06) == 8'h06) || ((m & 8'h09) == 8'h09);
    endfunction

    task automatic tracker_reset();
        hunt = HUNT_AA;
        cur_type = '0;
        cur_len = '0;
        body_idx = '0;
        foreach (body_buf[i])
            body_buf[i] = '0;
        crc_acc = CRC_INIT;
        crc_got = '0;
        seq_known = 1'b0;
        prev_seq = '0;
        latest = '0;
        ctl_ok = 1'b0;
        any_byte = 1'b0;
        gap_ms_cnt = '0;
        age_ms_cnt = '0;
        mode_on = 1'b0;
        gap_limit = INTERBYTE_RESET;
        stale_limit = STALE_RESET;
    endtask

    task automatic go_home();
        hunt = HUNT_AA;
        cur_len = '0;
        body_idx = '0;
    endtask

    task automatic accept_tracking(output event_t ev);
        if (seq_known && body_buf[0] == prev_seq) begin
            ctl_ok = 1'b0;
            ev = EV_DUP;
        end else begin
            seq_known = 1'b1;
            prev_seq = body_buf[0];
            latest.seq = body_buf[0];
            latest.flags = body_buf[1];
            latest.cx = {body_buf[3], body_buf[2]};
            latest.cy = {body_buf[5], body_buf[4]};
            latest.ex = {body_buf[7], body_buf[6]};
            latest.ey = {body_buf[9], body_buf[8]};
            latest.tags = body_buf[10];
            latest.fps = {body_buf[12], body_buf[11]};
            age_ms_cnt = '0;
            ctl_ok = mode_on && flags_usable(body_buf[1], body_buf[10]);
            ev = EV_OK;
        end
    endtask

    task automatic parse_serial_byte(input logic [7:0] b, output event_t ev);
        ev = EV_NONE;
        case (hunt)
            HUNT_AA:
                if (b == HDR1_BYTE)
                    hunt = HUNT_5A;
            HUNT_5A:
                if (b == HDR2_BYTE)
                    hunt = TAKE_TYPE;
                else if (b != HDR1_BYTE)
                    hunt = HUNT_AA;
            TAKE_TYPE:
            begin
                cur_type = b;
                crc_acc = crc_byte(CRC_INIT, b);
                hunt = TAKE_LEN;
            end
            TAKE_LEN:
            begin
                body_idx = '0;
                crc_acc = crc_byte(crc_acc, b);
                if (b > MAX_PAYLOAD || (cur_type == TRACK_TYPE && b != TRACK_LEN)) begin
                    ctl_ok = 1'b0;
                    go_home();
                    ev = EV_LEN;
                end else begin
                    cur_len = b[5:0];
                    hunt = (b == 8'h00) ? TAKE_CRC_LO : TAKE_BODY;
                end
            end
            TAKE_BODY:
            begin
                if ({2'b00, body_idx} < MAX_PAYLOAD)
                    body_buf[body_idx[4:0]] = b;
                body_idx = body_idx + 6'd1;
                crc_acc = crc_byte(crc_acc, b);
                if (body_idx >= cur_len)
                    hunt = TAKE_CRC_LO;
            end
            TAKE_CRC_LO:
            begin
                crc_got = {8'h00, b};
                hunt = TAKE_CRC_HI;
            end
            TAKE_CRC_HI:
            begin
                crc_got = {b, crc_got[7:0]};
                if (crc_got != crc_acc) begin
                    ctl_ok = 1'b0;
                    ev = EV_CRC;
                end else if (cur_type != TRACK_TYPE) begin
                    ctl_ok = 1'b0;
                    ev = EV_TYPE;
                end else if ({2'b00, cur_len} != TRACK_LEN) begin
                    ctl_ok = 1'b0;
                    ev = EV_LEN;
                end else begin
                    accept_tracking(ev);
                end
                go_home();
            end
            default:
            begin
                ctl_ok = 1'b0;
                go_home();
            end
        endcase
    endtask

    task automatic track_item(input logic act, input logic [7:0] b,
                              output track_result_t r);
        event_t ev;
        event_t pev;
        ev = EV_NONE;
        if (act == ACT_TICK) begin
            if (gap_ms_cnt != 16'hFFFF)
                gap_ms_cnt++;
            if (age_ms_cnt != 16'hFFFF)
                age_ms_cnt++;
            if (ctl_ok && age_ms_cnt > stale_limit) begin
                ctl_ok = 1'b0;
                ev = EV_STALE;
            end
        end else begin
            // A long silence drops any half-received frame before this byte.
            if (any_byte && gap_ms_cnt > gap_limit) begin
                ctl_ok = 1'b0;
                go_home();
                ev = EV_GAP;
            end
            gap_ms_cnt = '0;
            any_byte = 1'b1;
            parse_serial_byte(b, pev);
            if (pev != EV_NONE)
                ev = pev;
        end
        r = latest;
        r.ev = ev;
        r.ctl = ctl_ok;
    endtask

    task automatic offer_item(input logic act, input logic [7:0] b,
                              input logic pinned, input event_t pin_ev);
        track_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        byte_value <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_item(act, b, r);
        if (pinned)
            r.ev = pin_ev;
        expected_q.push_back(r);
        items_in++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        while (expected_q.size() != 0)
            @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            CFG_MODE:
                if (val[0] != mode_on) begin
                    mode_on = val[0];
                    ctl_ok = 1'b0;
                end
            CFG_INTERBYTE: gap_limit = val;
            CFG_STALE:     stale_limit = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic push_tick();
        stim_q.push_back('{ACT_TICK, 8'h00});
    endtask

    task automatic push_byte(input logic [7:0] b);
        // Now and then the line goes quiet in the middle of a frame.
        if ($urandom_range(99) < 2)
            repeat ($urandom_range(6, 1)) push_tick();
        stim_q.push_back('{ACT_BYTE, b});
    endtask

    task automatic plan_frame(input logic [7:0] ftype, input logic [7:0] flen,
                              input logic [7:0] body [$], input logic spoil);
        logic [15:0] c;
        c = crc_byte(crc_byte(CRC_INIT, ftype), flen);
        foreach (body[i])
            c = crc_byte(c, body[i]);
        if (spoil)
            c = c ^ (16'h0001 << $urandom_range(15));
        push_byte(HDR1_BYTE);
        push_byte(HDR2_BYTE);
        push_byte(ftype);
        push_byte(flen);
        foreach (body[i])
            push_byte(body[i]);
        push_byte(c[7:0]);
        push_byte(c[15:8]);
    endtask

    task automatic plan_sequence();
        int         roll;
        int         n;
        logic [7:0] body [$];
        logic [7:0] ftype;
        logic [7:0] flags;
        logic [7:0] mask;
        roll = $urandom_range(99);
        if (roll < 55) begin
            // Tracking frame; a few reuse the previous sequence number.
            if ($urandom_range(99) >= 6)
                seq_plan = seq_plan + 8'($urandom_range(3, 1));
            case ($urandom_range(3))
                0, 1:
                begin
                    flags = 8'h07;
                    mask = ($urandom_range(99) < 85) ? 8'h0F : 8'($urandom_range(255));
                end
                2:
                begin
                    flags = 8'h45;
                    mask = ($urandom_range(1) ? 8'h06 : 8'h09) | 8'($urandom_range(15));
                    if ($urandom_range(99) < 15)
                        mask = 8'($urandom_range(255));
                end
                default:
                begin
                    flags = 8'($urandom_range(255));
                    mask = 8'($urandom_range(255));
                end
            endcase
            body.push_back(seq_plan);
            body.push_back(flags);
            repeat (8) body.push_back(8'($urandom_range(255)));
            body.push_back(mask);
            repeat (2) body.push_back(8'($urandom_range(255)));
            plan_frame(TRACK_TYPE, TRACK_LEN, body, $urandom_range(99) < 8);
        end else if (roll < 65) begin
            ftype = 8'($urandom_range(255));
            if (ftype == TRACK_TYPE)
                ftype = 8'h22;
            n = ($urandom_range(99) < 80) ? $urandom_range(6) : $urandom_range(32, 7);
            repeat (n) body.push_back(8'($urandom_range(255)));
            plan_frame(ftype, 8'(n), body, $urandom_range(99) < 15);
        end else if (roll < 72) begin
            ftype = ($urandom_range(1) != 0) ? TRACK_TYPE : 8'($urandom_range(255));
            push_byte(HDR1_BYTE);
            push_byte(HDR2_BYTE);
            push_byte(ftype);
            if (ftype == TRACK_TYPE)
                push_byte(($urandom_range(1) != 0) ? 8'h0C : 8'($urandom_range(255, 14)));
            else
                push_byte(8'($urandom_range(255, 33)));
        end else if (roll < 84) begin
            n = ($urandom_range(99) < 75) ? $urandom_range(8, 1) : $urandom_range(70, 30);
            repeat (n) push_tick();
        end else if (roll < 93) begin
            repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
        end else begin
            // A frame cut short; whatever follows is swallowed as its body.
            push_byte(HDR1_BYTE);
            push_byte(HDR2_BYTE);
            push_byte(TRACK_TYPE);
            push_byte(TRACK_LEN);
            repeat ($urandom_range(12)) push_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic run_opening();
        logic       act;
        logic [7:0] b;
        foreach (OPENING[i]) begin
            act = (OPENING[i].kind == ROW_TICK) ? ACT_TICK : ACT_BYTE;
            case (OPENING[i].kind)
                ROW_CRC_LO:  b = crc_acc[7:0];
                ROW_CRC_HI:  b = crc_acc[15:8];
                ROW_CRC_BAD: b = ~crc_acc[15:8];
                default:     b = OPENING[i].b;
            endcase
            offer_item(act, b, OPENING[i].pinned, OPENING[i].ev);
        end
        in_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n, input int idle_pct, input int hold_pct);
        int           target;
        serial_item_t it;
        send_idle_pct = idle_pct;
        stall_pct = hold_pct;
        target = items_in + n;
        while (items_in < target || stim_q.size() != 0) begin
            if (stim_q.size() == 0)
                plan_sequence();
            it = stim_q.pop_front();
            offer_item(it.act, it.b, 1'b0, EV_NONE);
        end
        in_valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        track_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            results_out++;
            ev_hits[event_res]++;
            if (control_valid)
                ctl_results++;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, event %0d", $time, event_res);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                compare_field("event_res", 16'(want.ev), 16'(event_res));
                compare_field("control_valid", 16'(want.ctl), 16'(control_valid));
                compare_field("center_x", want.cx, center_x);
                compare_field("center_y", want.cy, center_y);
                compare_field("error_x", want.ex, error_x);
                compare_field("error_y", want.ey, error_y);
                compare_field("status_flags", 16'(want.flags), 16'(status_flags));
                compare_field("tags_seen", 16'(want.tags), 16'(tags_seen));
                compare_field("frame_rate_x10", want.fps, frame_rate_x10);
                compare_field("frame_sequence", 16'(want.seq), 16'(frame_sequence));
            end
        end
    end

    // Result side: random stalls, plus a long hold whenever one is ordered.
    initial begin
        int hold_left;
        int holds_done;
        hold_left = 0;
        holds_done = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_orders != holds_done) begin
                holds_done = hold_orders;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("tracking_frame_receiver regression: fail");
        $finish;
    end

    initial begin
        foreach (ev_hits[i])
            ev_hits[i] = 0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= ACT_BYTE;
        byte_value <= 8'h00;
        cfg_write_en <= 1'b0;
        cfg_index <= CFG_MODE;
        cfg_data <= 16'h0000;
        seq_plan = 8'($urandom_range(255));
        tracker_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_opening();
        run_phase(90, 0, 0);

        write_reg(CFG_MODE, 16'h0001);
        write_reg(CFG_INTERBYTE, 16'd3);
        write_reg(CFG_STALE, 16'd5);
        run_phase(90, 45, 0);

        // Same mode value again must leave control valid alone.
        write_reg(CFG_MODE, 16'h0001);
        write_reg(CFG_INTERBYTE, 16'hFFFF);
        write_reg(CFG_STALE, 16'hFFFF);
        run_phase(90, 0, 45);

        write_reg(CFG_INTERBYTE, 16'h0000);
        write_reg(CFG_STALE, 16'h0000);
        run_phase(90, 30, 30);

        // The result side holds off while items keep coming, so the input backs up.
        write_reg(CFG_INTERBYTE, INTERBYTE_RESET);
        write_reg(CFG_STALE, 16'd30);
        hold_orders++;
        run_phase(90, 0, 10);

        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_MODE, 16'h0000);
        write_reg(CFG_INTERBYTE, 16'd10);
        write_reg(CFG_STALE, STALE_RESET);
        run_phase(80, 20, 20);

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d items and %0d results over six timeout settings.",
                 items_in, results_out);
        $display("Frames taken %0d, crc %0d, length %0d, type %0d, dup %0d, gap %0d, stale %0d, control valid %0d.",
                 ev_hits[EV_OK], ev_hits[EV_CRC], ev_hits[EV_LEN], ev_hits[EV_TYPE],
                 ev_hits[EV_DUP], ev_hits[EV_GAP], ev_hits[EV_STALE], ctl_results);
        if (fail_count == 0)
            $display("tracking_frame_receiver regression: pass");
        else
            $display("tracking_frame_receiver regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
design/tfr_pkg.sv
design/tfr_parser.sv
design/tfr_tracker.sv
design/tracking_frame_receiver.sv
dv/tb_top.sv
